[rtl/core/rcsd_pkg.sv]
// Shared types and constants of the RC stick command decoder.
package rcsd_pkg;

    // Stick and switch levels.
    localparam logic [10:0] CH_CENTER    = 11'd1024;
    localparam logic [10:0] THR_ZERO     = 11'd353;
    localparam logic [10:0] MODE_LOW     = 11'd500;
    localparam logic [10:0] MODE_HIGH    = 11'd1200;
    localparam logic [10:0] DISARM_LEVEL = 11'd900;

    // Gesture hold lengths in frames.
    localparam logic [7:0] ARM_HOLD_FRAMES   = 8'd20;
    localparam logic [7:0] CALIB_HOLD_FRAMES = 8'd50;

    // x / 671 = (x * RECIP_671) >> 35, exact for x below 2^26.
    localparam logic [25:0] RECIP_671 = 26'd51206764;
    // x / 10 = (x * RECIP_10) >> 21, exact for x below 2^18.
    localparam logic [17:0] RECIP_10  = 18'd209716;

    typedef enum logic [2:0] {
        CFG_ROLL_MAX  = 3'd0,
        CFG_PITCH_MAX = 3'd1,
        CFG_YAW_MAX   = 3'd2,
        CFG_CLIMB_MAX = 3'd3,
        CFG_PWM_MAX   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] roll_max;
        logic [15:0] pitch_max;
        logic [15:0] yaw_rate_max;
        logic [15:0] climb_max;
        logic [15:0] pwm_max;
    } t_cfg;

    typedef struct packed {
        logic [10:0] ch_roll;
        logic [10:0] ch_throttle;
        logic [10:0] ch_pitch;
        logic [10:0] ch_yaw;
        logic [10:0] ch_mode;
        logic [10:0] ch_disarm;
        logic        calib_pending;
    } t_frame;

    // Switch fields that ride along with the stick math.
    typedef struct packed {
        logic [10:0] ch_mode;
        logic [10:0] ch_disarm;
        logic        calib_pending;
    } t_side;

    // Sign and magnitude of each scaled stick, truncated toward zero.
    typedef struct packed {
        logic        roll_neg;
        logic [16:0] roll_mag;
        logic        pitch_neg;
        logic [16:0] pitch_mag;
        logic        yaw_neg;
        logic [16:0] yaw_mag;
        logic        climb_neg;
        logic [16:0] climb_mag;
        logic        thr_neg;
        logic [16:0] thr_mag;
    } t_scaled;

    // Stage advance strobes.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

endpackage

[rtl/core/rcsd_scale.sv]
// Two-stage stick scaling: channel offset times max, then divide by 671.
module rcsd_scale import rcsd_pkg::*; (
    input  logic     i_clk,
    input  t_pipe_en i_en,
    input  t_frame   i_frame,
    input  t_cfg     i_cfg,
    output t_scaled  o_scaled,
    output t_side    o_side
);

    typedef struct packed {
        logic        roll_neg;
        logic [25:0] roll_p;
        logic        pitch_neg;
        logic [25:0] pitch_p;
        logic        yaw_neg;
        logic [25:0] yaw_p;
        logic        climb_neg;
        logic [25:0] climb_p;
        logic        thr_neg;
        logic [25:0] thr_p;
    } t_prod;

    // Returns {sign, |ch - 1024| * max}.
    function automatic logic [26:0] stick_prod(input logic [10:0] ch,
                                               input logic [15:0] maxv);
        logic        neg;
        logic [10:0] mag;
        logic [26:0] p;
        neg = (ch < CH_CENTER);
        mag = neg ? (CH_CENTER - ch) : (ch - CH_CENTER);
        p   = mag * maxv;
        return {neg, p[25:0]};
    endfunction

    // Returns {sign, |ch - 353| * max / 2}; the halving folds 1342 into 671.
    function automatic logic [26:0] thr_prod(input logic [10:0] ch,
                                             input logic [15:0] maxv);
        logic        neg;
        logic [10:0] mag;
        logic [26:0] p;
        neg = (ch < THR_ZERO);
        mag = neg ? (THR_ZERO - ch) : (ch - THR_ZERO);
        p   = mag * maxv;
        return {neg, p[26:1]};
    endfunction

    function automatic logic [16:0] div671(input logic [25:0] p);
        logic [51:0] prod;
        prod = p * RECIP_671;
        return prod[51:35];
    endfunction

    t_prod   n_prod, r_prod;
    t_side   r_side1, r_side2;
    t_scaled n_scaled, r_scaled;

    always_comb begin
        {n_prod.roll_neg,  n_prod.roll_p}  = stick_prod(i_frame.ch_roll,     i_cfg.roll_max);
        {n_prod.pitch_neg, n_prod.pitch_p} = stick_prod(i_frame.ch_pitch,    i_cfg.pitch_max);
        {n_prod.yaw_neg,   n_prod.yaw_p}   = stick_prod(i_frame.ch_yaw,      i_cfg.yaw_rate_max);
        // Climb follows the throttle stick.
        {n_prod.climb_neg, n_prod.climb_p} = stick_prod(i_frame.ch_throttle, i_cfg.climb_max);
        {n_prod.thr_neg,   n_prod.thr_p}   = thr_prod(i_frame.ch_throttle,   i_cfg.pwm_max);
    end

    always_comb begin
        n_scaled.roll_neg  = r_prod.roll_neg;
        n_scaled.roll_mag  = div671(r_prod.roll_p);
        n_scaled.pitch_neg = r_prod.pitch_neg;
        n_scaled.pitch_mag = div671(r_prod.pitch_p);
        n_scaled.yaw_neg   = r_prod.yaw_neg;
        n_scaled.yaw_mag   = div671(r_prod.yaw_p);
        n_scaled.climb_neg = r_prod.climb_neg;
        n_scaled.climb_mag = div671(r_prod.climb_p);
        n_scaled.thr_neg   = r_prod.thr_neg;
        n_scaled.thr_mag   = div671(r_prod.thr_p);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_prod  <= n_prod;
            r_side1 <= '{ch_mode:       i_frame.ch_mode,
                         ch_disarm:     i_frame.ch_disarm,
                         calib_pending: i_frame.calib_pending};
        end
        if (i_en.s2) begin
            r_scaled <= n_scaled;
            r_side2  <= r_side1;
        end
    end

    assign o_scaled = r_scaled;
    assign o_side   = r_side2;

endmodule

[rtl/core/rcsd_cmd.sv]
// Deadbands, mode and arming state, gesture counters and the result register.
module rcsd_cmd import rcsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pipe_en           i_en,
    input  t_cfg               i_cfg,
    input  t_scaled            i_scaled,
    input  t_side              i_side,
    output logic signed [17:0] o_roll_cmd,
    output logic signed [17:0] o_pitch_cmd,
    output logic signed [17:0] o_yaw_cmd,
    output logic signed [17:0] o_climb_cmd,
    output logic signed [17:0] o_throttle_pwm,
    output logic               o_alt_hold,
    output logic               o_pos_hold,
    output logic               o_armed,
    output logic               o_arm_event,
    output logic               o_calib_set
);

    function automatic logic [20:0] times10(input logic [16:0] q);
        return 21'({q, 3'b000}) + 21'({q, 1'b0});
    endfunction

    function automatic logic [16:0] band10(input logic [16:0] q, input logic [15:0] maxv);
        return (times10(q) < 21'(maxv)) ? 17'd0 : q;
    endfunction

    // True when 2 * mag > max.
    function automatic logic is_big(input logic [16:0] mag, input logic [15:0] maxv);
        return 18'({mag, 1'b0}) > 18'(maxv);
    endfunction

    function automatic logic [17:0] to_cmd(input logic neg, input logic [16:0] mag);
        logic [17:0] u;
        u = {1'b0, mag};
        return neg ? (18'd0 - u) : u;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    logic [17:0] yaw_band3;
    logic [17:0] yaw_off_num;
    logic [35:0] yaw_off_prod;
    logic [14:0] r_yaw_off;

    logic [16:0] roll_mag, pitch_mag, yaw_mag, climb_mag;
    logic        roll_low, pitch_high, pitch_low, yaw_high, climb_low, climb_high;
    logic        arm_gest, calib_gest, armed_mid;
    logic [7:0]  arm_inc, calib_inc;

    logic        r_alt_hold, n_alt_hold;
    logic        r_pos_hold, n_pos_hold;
    logic        r_armed, n_armed;
    logic [7:0]  r_arm_cnt, n_arm_cnt;
    logic [7:0]  r_calib_cnt, n_calib_cnt;
    logic        n_arm_event, n_calib_set;
    logic [17:0] r_roll, r_pitch, r_yaw, r_climb, r_thr;
    logic        r_arm_event, r_calib_set;

    // Yaw band offset ceil(3 * max / 10), derived from the register.
    assign yaw_band3    = {1'b0, i_cfg.yaw_rate_max, 1'b0} + 18'(i_cfg.yaw_rate_max);
    assign yaw_off_num  = yaw_band3 + 18'd9;
    assign yaw_off_prod = yaw_off_num * RECIP_10;

    always_ff @(posedge i_clk) begin
        r_yaw_off <= yaw_off_prod[35:21];
    end

    always_comb begin
        roll_mag  = band10(i_scaled.roll_mag,  i_cfg.roll_max);
        pitch_mag = band10(i_scaled.pitch_mag, i_cfg.pitch_max);
        climb_mag = band10(i_scaled.climb_mag, i_cfg.climb_max);
        // Shifted band: subtract the band from values outside it.
        if (times10(i_scaled.yaw_mag) <= 21'(yaw_band3)) begin
            yaw_mag = 17'd0;
        end else begin
            yaw_mag = i_scaled.yaw_mag - 17'(r_yaw_off);
        end

        roll_low   = i_scaled.roll_neg   & is_big(roll_mag,  i_cfg.roll_max);
        pitch_high = !i_scaled.pitch_neg & is_big(pitch_mag, i_cfg.pitch_max);
        pitch_low  = i_scaled.pitch_neg  & is_big(pitch_mag, i_cfg.pitch_max);
        yaw_high   = !i_scaled.yaw_neg   & is_big(yaw_mag,   i_cfg.yaw_rate_max);
        climb_low  = i_scaled.climb_neg  & is_big(climb_mag, i_cfg.climb_max);
        climb_high = !i_scaled.climb_neg & is_big(climb_mag, i_cfg.climb_max);
    end

    always_comb begin
        n_alt_hold = r_alt_hold;
        n_pos_hold = r_pos_hold;
        // Exactly on a zone edge: hold the old mode.
        if (i_side.ch_mode < MODE_LOW) begin
            n_alt_hold = 1'b0;
            n_pos_hold = 1'b0;
        end else if (i_side.ch_mode > MODE_LOW && i_side.ch_mode < MODE_HIGH) begin
            n_alt_hold = 1'b1;
            n_pos_hold = 1'b0;
        end else if (i_side.ch_mode > MODE_HIGH) begin
            n_alt_hold = 1'b1;
            n_pos_hold = 1'b1;
        end

        armed_mid   = (i_side.ch_disarm > DISARM_LEVEL) ? 1'b0 : r_armed;
        arm_gest    = roll_low & pitch_high & yaw_high & climb_low;
        arm_inc     = sat_inc(r_arm_cnt);
        n_armed     = armed_mid;
        n_arm_event = 1'b0;
        if (arm_gest) begin
            n_arm_cnt = arm_inc;
            if (arm_inc > ARM_HOLD_FRAMES && !armed_mid) begin
                n_armed     = 1'b1;
                n_arm_event = 1'b1;
            end
        end else begin
            n_arm_cnt = 8'd0;
        end

        calib_gest  = !n_armed & roll_low & pitch_low & yaw_high & climb_high;
        calib_inc   = sat_inc(r_calib_cnt);
        n_calib_cnt = r_calib_cnt;
        n_calib_set = 1'b0;
        if (calib_gest) begin
            // Hold the count while a calibration is already pending.
            if (!i_side.calib_pending) begin
                n_calib_cnt = calib_inc;
                n_calib_set = (calib_inc > CALIB_HOLD_FRAMES);
            end
        end else begin
            n_calib_cnt = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_hold  <= 1'b0;
            r_pos_hold  <= 1'b0;
            r_armed     <= 1'b0;
            r_arm_cnt   <= 8'd0;
            r_calib_cnt <= 8'd0;
        end else if (i_en.s3) begin
            r_alt_hold  <= n_alt_hold;
            r_pos_hold  <= n_pos_hold;
            r_armed     <= n_armed;
            r_arm_cnt   <= n_arm_cnt;
            r_calib_cnt <= n_calib_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_roll      <= to_cmd(i_scaled.roll_neg,  roll_mag);
            r_pitch     <= to_cmd(i_scaled.pitch_neg, pitch_mag);
            r_yaw       <= to_cmd(i_scaled.yaw_neg,   yaw_mag);
            r_climb     <= to_cmd(i_scaled.climb_neg, climb_mag);
            r_thr       <= to_cmd(i_scaled.thr_neg,   i_scaled.thr_mag);
            r_arm_event <= n_arm_event;
            r_calib_set <= n_calib_set;
        end
    end

    assign o_roll_cmd     = r_roll;
    assign o_pitch_cmd    = r_pitch;
    assign o_yaw_cmd      = r_yaw;
    assign o_climb_cmd    = r_climb;
    assign o_throttle_pwm = r_thr;
    assign o_alt_hold     = r_alt_hold;
    assign o_pos_hold     = r_pos_hold;
    assign o_armed        = r_armed;
    assign o_arm_event    = r_arm_event;
    assign o_calib_set    = r_calib_set;

endmodule

[rtl/core/rc_stick_command_decoder.sv]
// Top level of the RC stick command decoder: input register, config, pipeline control.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_ready   | six 11-bit channels, calib_pending
//  out     | from blk  | o_out_valid / i_out_ready | five 18-bit commands, five flags
//  cfg     | to block  | i_cfg_we                  | i_cfg_index (3 b), i_cfg_data (16 b)
//
// Four register stages: input, product, divide by 671, result. One frame per cycle
// while out is not stalled; a taken frame moves through them in that order.
// Each stage accepts a beat when empty or draining, so bubbles fill while out is stalled.
// Synchronous active-low reset empties the pipeline, clears mode, arm and gesture state
// and loads the default maxima.
module rc_stick_command_decoder import rcsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [10:0]        i_ch_roll,
    input  logic [10:0]        i_ch_throttle,
    input  logic [10:0]        i_ch_pitch,
    input  logic [10:0]        i_ch_yaw,
    input  logic [10:0]        i_ch_mode,
    input  logic [10:0]        i_ch_disarm,
    input  logic               i_calib_pending,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_roll_cmd,
    output logic signed [17:0] o_pitch_cmd,
    output logic signed [17:0] o_yaw_cmd,
    output logic signed [17:0] o_climb_cmd,
    output logic signed [17:0] o_throttle_pwm,
    output logic               o_alt_hold,
    output logic               o_pos_hold,
    output logic               o_armed,
    output logic               o_arm_event,
    output logic               o_calib_set,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg     r_cfg;
    t_frame   r_frame;
    t_pipe_en en;
    t_scaled  scaled;
    t_side    side;

    logic r_v0, r_v1, r_v2, r_v3;
    logic rdy0, rdy1, rdy2, rdy3;
    logic in_acc, out_acc;

    assign out_acc = r_v3 & i_out_ready;
    assign rdy3    = !r_v3 | i_out_ready;
    assign rdy2    = !r_v2 | rdy3;
    assign rdy1    = !r_v1 | rdy2;
    assign rdy0    = !r_v0 | rdy1;
    assign in_acc  = i_in_valid & rdy0;

    assign en.s1 = r_v0 & rdy1;
    assign en.s2 = r_v1 & rdy2;
    assign en.s3 = r_v2 & rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= in_acc | (r_v0 & !en.s1);
            r_v1 <= en.s1  | (r_v1 & !en.s2);
            r_v2 <= en.s2  | (r_v2 & !en.s3);
            r_v3 <= en.s3  | (r_v3 & !out_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_frame <= '{ch_roll:       i_ch_roll,
                         ch_throttle:   i_ch_throttle,
                         ch_pitch:      i_ch_pitch,
                         ch_yaw:        i_ch_yaw,
                         ch_mode:       i_ch_mode,
                         ch_disarm:     i_ch_disarm,
                         calib_pending: i_calib_pending};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roll_max     <= 16'd3000;
            r_cfg.pitch_max    <= 16'd3000;
            r_cfg.yaw_rate_max <= 16'd20000;
            r_cfg.climb_max    <= 16'd500;
            r_cfg.pwm_max      <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROLL_MAX:  r_cfg.roll_max     <= i_cfg_data;
                CFG_PITCH_MAX: r_cfg.pitch_max    <= i_cfg_data;
                CFG_YAW_MAX:   r_cfg.yaw_rate_max <= i_cfg_data;
                CFG_CLIMB_MAX: r_cfg.climb_max    <= i_cfg_data;
                CFG_PWM_MAX:   r_cfg.pwm_max      <= i_cfg_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    rcsd_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_frame  (r_frame),
        .i_cfg    (r_cfg),
        .o_scaled (scaled),
        .o_side   (side)
    );

    rcsd_cmd u_cmd (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_cfg          (r_cfg),
        .i_scaled       (scaled),
        .i_side         (side),
        .o_roll_cmd     (o_roll_cmd),
        .o_pitch_cmd    (o_pitch_cmd),
        .o_yaw_cmd      (o_yaw_cmd),
        .o_climb_cmd    (o_climb_cmd),
        .o_throttle_pwm (o_throttle_pwm),
        .o_alt_hold     (o_alt_hold),
        .o_pos_hold     (o_pos_hold),
        .o_armed        (o_armed),
        .o_arm_event    (o_arm_event),
        .o_calib_set    (o_calib_set)
    );

    assign o_in_ready  = rdy0;
    assign o_out_valid = r_v3;

endmodule

[test/tb.sv]
// Self-checking testbench for rc_stick_command_decoder: stick frames, gestures, config sweeps.
module tb import rcsd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic signed [17:0] roll;
        logic signed [17:0] pitch;
        logic signed [17:0] yaw;
        logic signed [17:0] climb;
        logic signed [17:0] thr;
        logic               alt;
        logic               pos;
        logic               armed;
        logic               arm_ev;
        logic               calib;
    } t_stick_cmd;

    // Tracks expected commands: mirrors the decoder's maxima, mode and gesture state.
    class cmd_tracker;
        logic [15:0] roll_max;
        logic [15:0] pitch_max;
        logic [15:0] yaw_max;
        logic [15:0] climb_max;
        logic [15:0] pwm_max;
        logic [7:0]  arm_cnt;
        logic [7:0]  calib_cnt;
        logic        armed;
        logic        alt;
        logic        pos;
        t_stick_cmd  expected_cmds[$];
        int          errors;
        int          taken;

        function new();
            roll_max  = 16'd3000;
            pitch_max = 16'd3000;
            yaw_max   = 16'd20000;
            climb_max = 16'd500;
            pwm_max   = 16'd1000;
            arm_cnt   = '0;
            calib_cnt = '0;
            armed     = 1'b0;
            alt       = 1'b0;
            pos       = 1'b0;
            errors    = 0;
            taken     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] v);
            case (idx)
                CFG_ROLL_MAX:  roll_max  = v;
                CFG_PITCH_MAX: pitch_max = v;
                CFG_YAW_MAX:   yaw_max   = v;
                CFG_CLIMB_MAX: climb_max = v;
                CFG_PWM_MAX:   pwm_max   = v;
                default: ;
            endcase
        endfunction

        // Signed division truncates toward zero, as the decoder does.
        function longint scaled(logic [10:0] ch, logic [15:0] mx);
            return (longint'(ch) - longint'(CH_CENTER)) * longint'(mx) / 671;
        endfunction

        function longint band10(longint v, logic [15:0] mx);
            longint mag;
            mag = (v < 0) ? -v : v;
            if (mag * 10 < longint'(mx))
                return 0;
            return v;
        endfunction

        // Wide band with the band width taken off, so the edge gives zero.
        function longint band_yaw(longint v, logic [15:0] mx);
            longint mag;
            longint b3;
            mag = (v < 0) ? -v : v;
            b3  = 3 * longint'(mx);
            if (mag * 10 <= b3)
                return 0;
            if (v > 0)
                return (10 * v - b3) / 10;
            return (10 * v + b3) / 10;
        endfunction

        function void take_frame(t_frame f);
            longint     roll;
            longint     pitch;
            longint     yaw;
            longint     climb;
            longint     thr;
            bit         roll_low;
            bit         yaw_high;
            bit         arm_g;
            bit         calib_g;
            t_stick_cmd c;
            roll  = band10(scaled(f.ch_roll, roll_max), roll_max);
            climb = band10(scaled(f.ch_throttle, climb_max), climb_max);
            pitch = band10(scaled(f.ch_pitch, pitch_max), pitch_max);
            yaw   = band_yaw(scaled(f.ch_yaw, yaw_max), yaw_max);
            thr   = (longint'(f.ch_throttle) - longint'(THR_ZERO)) * longint'(pwm_max) / 1342;
            c.arm_ev = 1'b0;
            c.calib  = 1'b0;

            // Exactly on either mode level: keep the old mode.
            if (f.ch_mode < MODE_LOW) begin
                alt = 1'b0;
                pos = 1'b0;
            end else if (f.ch_mode > MODE_LOW && f.ch_mode < MODE_HIGH) begin
                alt = 1'b1;
                pos = 1'b0;
            end else if (f.ch_mode > MODE_HIGH) begin
                alt = 1'b1;
                pos = 1'b1;
            end

            if (f.ch_disarm > DISARM_LEVEL)
                armed = 1'b0;

            roll_low = 2 * roll < -longint'(roll_max);
            yaw_high = 2 * yaw > longint'(yaw_max);

            arm_g = roll_low && (2 * pitch > longint'(pitch_max)) && yaw_high &&
                    (2 * climb < -longint'(climb_max));
            if (arm_g) begin
                if (arm_cnt != 8'hFF)
                    arm_cnt++;
                if (arm_cnt > ARM_HOLD_FRAMES && !armed) begin
                    armed    = 1'b1;
                    c.arm_ev = 1'b1;
                end
            end else begin
                arm_cnt = '0;
            end

            calib_g = !armed && roll_low && (2 * pitch < -longint'(pitch_max)) && yaw_high &&
                      (2 * climb > longint'(climb_max));
            if (calib_g) begin
                // Pending request freezes the count.
                if (!f.calib_pending) begin
                    if (calib_cnt != 8'hFF)
                        calib_cnt++;
                    if (calib_cnt > CALIB_HOLD_FRAMES)
                        c.calib = 1'b1;
                end
            end else begin
                calib_cnt = '0;
            end

            c.roll  = roll[17:0];
            c.pitch = pitch[17:0];
            c.yaw   = yaw[17:0];
            c.climb = climb[17:0];
            c.thr   = thr[17:0];
            c.alt   = alt;
            c.pos   = pos;
            c.armed = armed;
            expected_cmds.push_back(c);
            taken++;
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void match_cmd(t_stick_cmd got);
            t_stick_cmd want;
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t: command beat with nothing expected", $time);
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("roll_cmd", want.roll, got.roll);
            compare_field("pitch_cmd", want.pitch, got.pitch);
            compare_field("yaw_cmd", want.yaw, got.yaw);
            compare_field("climb_cmd", want.climb, got.climb);
            compare_field("throttle_pwm", want.thr, got.thr);
            compare_field("alt_hold", want.alt, got.alt);
            compare_field("pos_hold", want.pos, got.pos);
            compare_field("armed", want.armed, got.armed);
            compare_field("arm_event", want.arm_ev, got.arm_ev);
            compare_field("calib_set", want.calib, got.calib);
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_frame   in_frame  = '0;
    logic     out_ready = 1'b0;
    logic     cfg_we    = 1'b0;
    t_cfg_idx cfg_index = CFG_ROLL_MAX;
    logic [15:0] cfg_data = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [17:0] roll_cmd;
    logic signed [17:0] pitch_cmd;
    logic signed [17:0] yaw_cmd;
    logic signed [17:0] climb_cmd;
    logic signed [17:0] throttle_pwm;
    logic               alt_hold;
    logic               pos_hold;
    logic               armed;
    logic               arm_event;
    logic               calib_set;

    cmd_tracker tracker = new();
    int         idle_pct = 0;
    bit         long_hold_done = 1'b0;
    int         quiet_cycles = 0;

    rc_stick_command_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_ch_roll       (in_frame.ch_roll),
        .i_ch_throttle   (in_frame.ch_throttle),
        .i_ch_pitch      (in_frame.ch_pitch),
        .i_ch_yaw        (in_frame.ch_yaw),
        .i_ch_mode       (in_frame.ch_mode),
        .i_ch_disarm     (in_frame.ch_disarm),
        .i_calib_pending (in_frame.calib_pending),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_roll_cmd      (roll_cmd),
        .o_pitch_cmd     (pitch_cmd),
        .o_yaw_cmd       (yaw_cmd),
        .o_climb_cmd     (climb_cmd),
        .o_throttle_pwm  (throttle_pwm),
        .o_alt_hold      (alt_hold),
        .o_pos_hold      (pos_hold),
        .o_armed         (armed),
        .o_arm_event     (arm_event),
        .o_calib_set     (calib_set),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run when no beat moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [10:0] pick_ch();
        logic [10:0] base;
        case ($urandom_range(0, 3))
            0: base = MODE_LOW;
            1: base = MODE_HIGH;
            2: base = DISARM_LEVEL;
            default: base = THR_ZERO;
        endcase
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'd2047;
            2: return CH_CENTER + 11'($urandom_range(0, 160)) - 11'd80;
            3: return base + 11'($urandom_range(0, 2)) - 11'd1;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic t_frame mk_frame(int r, int t, int p, int y, int m, int d, int pend);
        t_frame f;
        f.ch_roll       = 11'(r);
        f.ch_throttle   = 11'(t);
        f.ch_pitch      = 11'(p);
        f.ch_yaw        = 11'(y);
        f.ch_mode       = 11'(m);
        f.ch_disarm     = 11'(d);
        f.calib_pending = 1'(pend);
        return f;
    endfunction

    function automatic t_frame noise_frame();
        return mk_frame(pick_ch(), pick_ch(), pick_ch(), pick_ch(), pick_ch(), pick_ch(),
                        $urandom_range(0, 1));
    endfunction

    // Roll left, pitch up, yaw right, throttle down.
    function automatic t_frame arm_frame();
        int dis;
        dis = ($urandom_range(0, 7) == 0) ? $urandom_range(901, 2047) : $urandom_range(0, 900);
        return mk_frame($urandom_range(0, 300), $urandom_range(0, 300),
                        $urandom_range(1750, 2047), $urandom_range(1800, 2047),
                        pick_ch(), dis, $urandom_range(0, 1));
    endfunction

    // Roll left, pitch down, yaw right, throttle up, mostly disarmed.
    function automatic t_frame calib_frame();
        int dis;
        int pend;
        dis  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 900) : $urandom_range(901, 2047);
        pend = ($urandom_range(0, 7) == 0) ? 1 : 0;
        return mk_frame($urandom_range(0, 300), $urandom_range(1750, 2047),
                        $urandom_range(0, 300), $urandom_range(1800, 2047),
                        pick_ch(), dis, pend);
    endfunction

    task automatic send(input t_frame f);
        int n;
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_frame <= f;
        do @(posedge clk); while (!o_in_ready);
        tracker.take_frame(f);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        tracker.set_reg(idx, v);
    endtask

    task automatic load_maxima(input logic [15:0] r, input logic [15:0] p, input logic [15:0] y,
                               input logic [15:0] c, input logic [15:0] w);
        put_reg(CFG_ROLL_MAX, r);
        put_reg(CFG_PITCH_MAX, p);
        put_reg(CFG_YAW_MAX, y);
        put_reg(CFG_CLIMB_MAX, c);
        put_reg(CFG_PWM_MAX, w);
        cfg_we <= 1'b0;
    endtask

    // Drain every expected command, then let the pipeline go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic hold_arm(input int len);
        for (int i = 0; i < len; i++)
            send(($urandom_range(0, 29) == 0) ? noise_frame() : arm_frame());
    endtask

    task automatic hold_calib(input int len);
        for (int i = 0; i < len; i++)
            send(($urandom_range(0, 29) == 0) ? noise_frame() : calib_frame());
    endtask

    task automatic random_mix(input int n);
        int left;
        int len;
        left = n;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    len = $urandom_range(18, 28);
                    hold_arm(len);
                end
                4, 5, 6: begin
                    len = $urandom_range(45, 58);
                    hold_calib(len);
                end
                default: begin
                    len = $urandom_range(1, 6);
                    repeat (len) send(noise_frame());
                end
            endcase
            left -= len;
        end
    endtask

    // Extremes, mode levels, disarm level and deadband edges at default maxima.
    task automatic directed();
        send(mk_frame(0, 0, 0, 0, 0, 0, 0));
        send(mk_frame(2047, 2047, 2047, 2047, 2047, 2047, 1));
        send(mk_frame(1024, 1024, 1024, 1024, 1201, 0, 0));
        send(mk_frame(1024, 353, 1024, 1024, 500, 0, 0));
        send(mk_frame(1091, 354, 1092, 1024, 499, 900, 1));
        send(mk_frame(956, 352, 957, 1024, 1200, 901, 0));
        send(mk_frame(1024, 1024, 1024, 1225, 501, 0, 0));
        send(mk_frame(1024, 1024, 1024, 1226, 1199, 0, 0));
        send(mk_frame(1024, 1024, 1024, 822, 1200, 0, 0));
        send(mk_frame(1024, 1024, 1024, 823, 500, 0, 0));
        send(mk_frame(1695, 1695, 1695, 1695, 1201, 899, 0));
        send(mk_frame(353, 353, 353, 353, 1024, 1, 1));
        send(mk_frame(1, 2046, 1, 2046, 1024, 1, 1));
        send(mk_frame(2046, 1, 2046, 1, 1024, 2046, 0));
        send(mk_frame(0, 0, 2047, 2047, 1024, 0, 0));
        send(mk_frame(0, 2047, 0, 2047, 1024, 2047, 1));
        send(mk_frame(0, 2047, 0, 2047, 1024, 2047, 0));
    endtask

    initial begin : sink
        int         n;
        t_stick_cmd got;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!long_hold_done && tracker.taken >= 150) begin
                // Hold off long enough to back the pipeline up into the input.
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (64) @(posedge clk);
            end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (o_out_valid && out_ready) begin
                got.roll   = roll_cmd;
                got.pitch  = pitch_cmd;
                got.yaw    = yaw_cmd;
                got.climb  = climb_cmd;
                got.thr    = throttle_pwm;
                got.alt    = alt_hold;
                got.pos    = pos_hold;
                got.armed  = armed;
                got.arm_ev = arm_event;
                got.calib  = calib_set;
                tracker.match_cmd(got);
            end
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_maxima(16'd3000, 16'd3000, 16'd20000, 16'd500, 16'd1000);
        idle_pct = 20;
        directed();
        random_mix(10);
        // Unbroken arm hold runs the counter into saturation, with disarm flicks.
        repeat (258) send(arm_frame());
        settle();

        load_maxima(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_pct = 40;
        random_mix(10);
        settle();

        load_maxima(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        idle_pct = 10;
        repeat (15) send(noise_frame());
        settle();

        load_maxima(16'($urandom_range(200, 65535)), 16'($urandom_range(200, 65535)),
                    16'($urandom_range(200, 65535)), 16'($urandom_range(200, 65535)),
                    16'($urandom_range(0, 65535)));
        idle_pct = 25;
        // Unbroken calibration hold long enough to complete the gesture.
        repeat (64) send(calib_frame());
        random_mix(5);
        settle();

        load_maxima(16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)), 16'd7, 16'hFFFF);
        idle_pct = 0;
        random_mix(15);
        settle();

        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
